// ----- hdl/chb_pkg.sv -----
// shared types, constants and fixed-point helpers for the hermite basis core
package chb_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QW = 32;
  localparam int OW = 20;
  localparam int NUM_TERMS = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [OW-1:0] o_t;

  typedef struct packed {
    q_t [3:0] val;
    q_t [3:0] d1;
    q_t [3:0] d2;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
    logic [1:0] dim;
  } entry_t;

  localparam logic [1:0] DIM_LINE = 2'd1;
  localparam logic [1:0] DIM_QUAD = 2'd2;

  localparam logic [1:0] KIND_V = 2'd0;
  localparam logic [1:0] KIND_D = 2'd1;
  localparam logic [1:0] KIND_E = 2'd2;

  localparam logic [1:0] LINE_ORDER [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
  localparam logic [1:0] QUAD_BX [4] = '{2'd0, 2'd2, 2'd2, 2'd0};
  localparam logic [1:0] QUAD_BY [4] = '{2'd0, 2'd0, 2'd2, 2'd2};
  localparam logic [1:0] HEX_BX [8] = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0};
  localparam logic [1:0] HEX_BY [8] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2};
  localparam logic [1:0] HEX_BZ [8] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2};
  localparam logic HEX_OX [8] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam logic HEX_OY [8] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic HEX_OZ [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  // factor kind per output term: value, gradient xyz, hessian diag, mixed
  localparam logic [1:0] TERM_KX [NUM_TERMS] = '{KIND_V, KIND_D, KIND_V, KIND_V, KIND_E,
                                                 KIND_V, KIND_V, KIND_D, KIND_D, KIND_V};
  localparam logic [1:0] TERM_KY [NUM_TERMS] = '{KIND_V, KIND_V, KIND_D, KIND_V, KIND_V,
                                                 KIND_E, KIND_V, KIND_D, KIND_V, KIND_D};
  localparam logic [1:0] TERM_KZ [NUM_TERMS] = '{KIND_V, KIND_V, KIND_V, KIND_D, KIND_V,
                                                 KIND_V, KIND_E, KIND_V, KIND_D, KIND_D};
  localparam logic [NUM_TERMS-1:0] LINE_MASK = 10'b00_0001_0011;
  localparam logic [NUM_TERMS-1:0] QUAD_MASK = 10'b00_1011_0111;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return q_t'(32'sh7fffffff);
    if (v < -64'sd2147483648) return q_t'(32'sh80000000);
    return q_t'(v[QW-1:0]);
  endfunction

  function automatic o_t sat20(input q_t v);
    if (v > 32'sd524287) return o_t'(20'sh7ffff);
    if (v < -32'sd524288) return o_t'(20'sh80000);
    return o_t'(v[OW-1:0]);
  endfunction

  // q-format multiply, round half up, result saturated to 32 bits
  function automatic q_t mulq(input q_t a, input q_t b, input int frac);
    logic signed [63:0] p;
    p = a * b;
    p = p + (64'sd1 <<< (frac - 1));
    p = p >>> frac;
    return sat32(p);
  endfunction

endpackage

// ----- hdl/chb_in_if.sv -----
// point channel: valid, ready and three reference coordinates
interface chb_in_if;
  logic valid;
  logic ready;
  logic signed [17:0] coord_x;
  logic signed [17:0] coord_y;
  logic signed [17:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// ----- hdl/chb_out_if.sv -----
// result channel: valid, ready and one basis function's value and derivatives
interface chb_out_if;
  logic valid;
  logic ready;
  logic [5:0] dof_index;
  logic signed [19:0] basis_value;
  logic signed [19:0] grad_x;
  logic signed [19:0] grad_y;
  logic signed [19:0] grad_z;
  logic signed [19:0] hess_xx;
  logic signed [19:0] hess_yy;
  logic signed [19:0] hess_zz;
  logic signed [19:0] hess_xy;
  logic signed [19:0] hess_xz;
  logic signed [19:0] hess_yz;
  logic last_dof;
  modport source (output valid, dof_index, basis_value, grad_x, grad_y, grad_z, hess_xx,
                  hess_yy, hess_zz, hess_xy, hess_xz, hess_yz, last_dof, input ready);
  modport sink (input valid, dof_index, basis_value, grad_x, grad_y, grad_z, hess_xx,
                hess_yy, hess_zz, hess_xy, hess_xz, hess_yz, last_dof, output ready);
endinterface

// ----- hdl/chb_front.sv -----
// front end: takes points and evaluates the per-axis hermite modes
module chb_front import chb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] dimension,
  chb_in_if.sink     pt_in,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_data
);

  logic en;
  logic v0, v1, v2, v3;
  logic signed [17:0] s0 [3];
  logic signed [17:0] s1 [3];
  logic signed [17:0] s2 [3];
  q_t sq1 [3];
  q_t sq2 [3];
  q_t cu2 [3];
  logic [1:0] dim0, dim1, dim2;
  entry_t entry3;

  function automatic axis_t modes(input logic signed [17:0] s, input q_t sq, input q_t cu);
    logic signed [35:0] sw, qw, cw, one;
    logic signed [35:0] n [12];
    axis_t a;
    sw = 36'(s);
    qw = 36'(sq);
    cw = 36'(cu);
    one = 36'sd1 <<< FRAC_BITS;
    n[0] = 2 * one - 3 * sw + cw;
    n[1] = one - sw - qw + cw;
    n[2] = 2 * one + 3 * sw - cw;
    n[3] = -one - sw + qw + cw;
    n[4] = -3 * one + 3 * qw;
    n[5] = -one - 2 * sw + 3 * qw;
    n[6] = 3 * one - 3 * qw;
    n[7] = -one + 2 * sw + 3 * qw;
    n[8] = 6 * sw;
    n[9] = -2 * one + 6 * sw;
    n[10] = -6 * sw;
    n[11] = 2 * one + 6 * sw;
    for (int i = 0; i < 4; i++) begin
      a.val[i] = sat32(64'((n[i] + 36'sd2) >>> 2));
      a.d1[i] = sat32(64'((n[4+i] + 36'sd2) >>> 2));
      a.d2[i] = sat32(64'((n[8+i] + 36'sd2) >>> 2));
    end
    return a;
  endfunction

  // whole pipe holds when the last stage cannot hand off
  assign en = !(v3 && !push_ready);
  assign pt_in.ready = en;
  assign push_valid = v3;
  assign push_data = entry3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= pt_in.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0[0] <= pt_in.coord_x;
      s0[1] <= pt_in.coord_y;
      s0[2] <= pt_in.coord_z;
      dim0 <= dimension;
      dim1 <= dim0;
      dim2 <= dim1;
      for (int i = 0; i < 3; i++) begin
        s1[i] <= s0[i];
        sq1[i] <= mulq(q_t'(s0[i]), q_t'(s0[i]), FRAC_BITS);
        s2[i] <= s1[i];
        sq2[i] <= sq1[i];
        cu2[i] <= mulq(sq1[i], q_t'(s1[i]), FRAC_BITS);
      end
      entry3.x <= modes(s2[0], sq2[0], cu2[0]);
      entry3.y <= modes(s2[1], sq2[1], cu2[1]);
      entry3.z <= modes(s2[2], sq2[2], cu2[2]);
      entry3.dim <= dim2;
    end
  end

endmodule

// ----- hdl/chb_queue.sv -----
// short queue of evaluated points between front and back
module chb_queue import chb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] fill;
  logic do_push, do_pop;

  assign push_ready = fill != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_data = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- hdl/chb_back.sv -----
// back end: walks the dofs of a point and forms tensor products
module chb_back import chb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  entry_t pop_data,
  chb_out_if.source res_out
);

  logic adv, cur_valid, last_k;
  entry_t cur;
  logic [5:0] k, k_end;
  logic [1:0] ix, iy, iz;
  logic is_line, is_quad;
  q_t fa [NUM_TERMS];
  q_t fb [NUM_TERMS];
  q_t fc [NUM_TERMS];
  logic [NUM_TERMS-1:0] mask;
  q_t one;

  logic p1v, p1_last;
  logic [5:0] p1_idx;
  q_t p1_ab [NUM_TERMS];
  q_t p1_c [NUM_TERMS];

  logic ov, o_last;
  logic [5:0] o_idx;
  o_t o_r [NUM_TERMS];

  function automatic q_t pick(input axis_t a, input logic [1:0] kind, input logic [1:0] idx);
    case (kind)
      KIND_V: return a.val[idx];
      KIND_D: return a.d1[idx];
      default: return a.d2[idx];
    endcase
  endfunction

  assign one = q_t'(32'sd1 <<< FRAC_BITS);
  assign adv = !ov || res_out.ready;
  assign is_line = cur.dim == DIM_LINE;
  assign is_quad = cur.dim == DIM_QUAD;
  assign k_end = is_line ? 6'd3 : is_quad ? 6'd15 : 6'd63;
  assign last_k = k == k_end;
  assign pop_ready = adv && (!cur_valid || last_k);

  always_comb begin
    if (is_line) begin
      ix = LINE_ORDER[k[1:0]];
      iy = 2'd0;
      iz = 2'd0;
      mask = LINE_MASK;
    end else if (is_quad) begin
      ix = QUAD_BX[k[3:2]] + {1'b0, k[0]};
      iy = QUAD_BY[k[3:2]] + {1'b0, k[1]};
      iz = 2'd0;
      mask = QUAD_MASK;
    end else begin
      ix = HEX_BX[k[5:3]] + {1'b0, HEX_OX[k[2:0]]};
      iy = HEX_BY[k[5:3]] + {1'b0, HEX_OY[k[2:0]]};
      iz = HEX_BZ[k[5:3]] + {1'b0, HEX_OZ[k[2:0]]};
      mask = '1;
    end
    for (int j = 0; j < NUM_TERMS; j++) begin
      fa[j] = mask[j] ? pick(cur.x, TERM_KX[j], ix) : '0;
      fb[j] = is_line ? one : pick(cur.y, TERM_KY[j], iy);
      fc[j] = (is_line || is_quad) ? one : pick(cur.z, TERM_KZ[j], iz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k <= '0;
      p1v <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      p1v <= cur_valid;
      ov <= p1v;
      if (cur_valid && !last_k) begin
        k <= k + 1'b1;
      end else begin
        cur_valid <= pop_valid;
        k <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop_ready) cur <= pop_data;
      p1_idx <= k;
      p1_last <= last_k;
      o_idx <= p1_idx;
      o_last <= p1_last;
      for (int j = 0; j < NUM_TERMS; j++) begin
        p1_ab[j] <= mulq(fa[j], fb[j], FRAC_BITS);
        p1_c[j] <= fc[j];
        o_r[j] <= sat20(mulq(p1_ab[j], p1_c[j], FRAC_BITS));
      end
    end
  end

  assign res_out.valid = ov;
  assign res_out.dof_index = o_idx;
  assign res_out.basis_value = o_r[0];
  assign res_out.grad_x = o_r[1];
  assign res_out.grad_y = o_r[2];
  assign res_out.grad_z = o_r[3];
  assign res_out.hess_xx = o_r[4];
  assign res_out.hess_yy = o_r[5];
  assign res_out.hess_zz = o_r[6];
  assign res_out.hess_xy = o_r[7];
  assign res_out.hess_xz = o_r[8];
  assign res_out.hess_yz = o_r[9];
  assign res_out.last_dof = o_last;

endmodule

// ----- hdl/cubic_hermite_tensor_basis_core.sv -----
// top level of the cubic hermite tensor-product basis evaluator
//
//   channel   direction  transfer when         carries
//   pt_in     in         valid & ready        coord_x, coord_y, coord_z
//   res_out   out        valid & ready        dof_index, value, gradient, hessian, last_dof
//   cfg       in         cfg_we               dimension (2 bits)
//
// one result per cycle while res_out is ready; a point yields 4, 16 or 64 results, set by the back end's dof counter
// a point passes the front's pipeline, the queue, then the back's cur, p1 and output registers
// the front keeps taking points while the back walks earlier ones (two-entry queue)
// rst is synchronous; dimension returns to line
// a stalled res_out holds the back pipeline; the front fills the queue and then holds pt_in
module cubic_hermite_tensor_basis_core import chb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  chb_in_if.sink     pt_in,
  chb_out_if.source  res_out
);

  logic [1:0] dimension;
  logic push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  // element dimension register, zero falls through to hex in the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_LINE;
    end else if (cfg_we) begin
      dimension <= cfg_wdata;
    end
  end

  // axis mode evaluation
  chb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .dimension  (dimension),
    .pt_in      (pt_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples point evaluation from dof emission
  chb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // dof sequencer and tensor products
  chb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_out   (res_out)
  );

endmodule

// ----- test/chb_checker.sv -----
`timescale 1ns / 1ps
// result checker: predicts basis values for each point transfer and compares results
module chb_checker import chb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic [1:0] cfg_wdata,
  chb_in_if      pt_mon,
  chb_out_if     res_mon,
  output int     fail_count,
  output int     pending_count
);

  typedef struct packed {
    logic [5:0] dof;
    logic signed [9:0] [19:0] term;
    logic last;
  } basis_res_t;

  typedef logic signed [63:0] wide_t;

  basis_res_t pending_res[$];
  logic [1:0] dim_reg;

  function automatic wide_t clamp32(wide_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic wide_t qmul(wide_t a, wide_t b);
    wide_t p;
    p = clamp32(a) * clamp32(b);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [19:0] clamp20(wide_t v);
    if (v > 64'sd524287) return 20'sh7ffff;
    if (v < -64'sd524288) return 20'sh80000;
    return v[19:0];
  endfunction

  // mode table: kind 0 value, 1 first, 2 second derivative
  function automatic void axis_eval(input logic signed [17:0] raw,
                                    output wide_t m[3][4]);
    wide_t s, s2, s3, one;
    one = 64'sd65536;
    s = raw;
    s2 = qmul(s, s);
    s3 = qmul(s2, s);
    m[0][0] = (2*one - 3*s + s3 + 2) >>> 2;
    m[0][1] = (one - s - s2 + s3 + 2) >>> 2;
    m[0][2] = (2*one + 3*s - s3 + 2) >>> 2;
    m[0][3] = (-one - s + s2 + s3 + 2) >>> 2;
    m[1][0] = (-3*one + 3*s2 + 2) >>> 2;
    m[1][1] = (-one - 2*s + 3*s2 + 2) >>> 2;
    m[1][2] = (3*one - 3*s2 + 2) >>> 2;
    m[1][3] = (-one + 2*s + 3*s2 + 2) >>> 2;
    m[2][0] = (6*s + 2) >>> 2;
    m[2][1] = (-2*one + 6*s + 2) >>> 2;
    m[2][2] = (-6*s + 2) >>> 2;
    m[2][3] = (2*one + 6*s + 2) >>> 2;
  endfunction

  task automatic predict_point(logic signed [17:0] cx, logic signed [17:0] cy,
                               logic signed [17:0] cz);
    wide_t mx[3][4], my[3][4], mz[3][4];
    int kx[10], ky[10], kz[10];
    int count, c, l, ix, iy, iz;
    basis_res_t r;
    int bx[8], by[8], bz[8], ox[8], oy[8], oz[8];
    kx = '{0, 1, 0, 0, 2, 0, 0, 1, 1, 0};
    ky = '{0, 0, 1, 0, 0, 2, 0, 1, 0, 1};
    kz = '{0, 0, 0, 1, 0, 0, 2, 0, 1, 1};
    bx = '{0, 2, 2, 0, 0, 2, 2, 0};
    by = '{0, 0, 2, 2, 0, 0, 2, 2};
    bz = '{0, 0, 0, 0, 2, 2, 2, 2};
    ox = '{0, 1, 0, 0, 1, 1, 0, 1};
    oy = '{0, 0, 1, 0, 1, 0, 1, 1};
    oz = '{0, 0, 0, 1, 0, 1, 1, 1};
    axis_eval(cx, mx);
    axis_eval(cy, my);
    axis_eval(cz, mz);
    count = (dim_reg == DIM_LINE) ? 4 : (dim_reg == DIM_QUAD) ? 16 : 64;
    for (int k = 0; k < count; k++) begin
      r = '0;
      r.dof = k[5:0];
      r.last = (k == count - 1);
      if (count == 4) begin
        ix = (k == 1) ? 2 : (k == 2) ? 1 : k;
        r.term[0] = clamp20(mx[0][ix]);
        r.term[1] = clamp20(mx[1][ix]);
        r.term[4] = clamp20(mx[2][ix]);
      end else if (count == 16) begin
        c = k >> 2;
        l = k & 3;
        ix = (bx[c] + (l & 1)) & 3;
        iy = (by[c] + ((l >> 1) & 1)) & 3;
        foreach (kx[j]) begin
          if (kz[j] == 0 && j != 3 && j != 6)
            r.term[j] = clamp20(qmul(mx[kx[j]][ix], my[ky[j]][iy]));
        end
      end else begin
        c = k >> 3;
        l = k & 7;
        ix = (bx[c] + ox[l]) & 3;
        iy = (by[c] + oy[l]) & 3;
        iz = (bz[c] + oz[l]) & 3;
        foreach (kx[j])
          r.term[j] = clamp20(qmul(qmul(mx[kx[j]][ix], my[ky[j]][iy]), mz[kz[j]][iz]));
      end
      pending_res.push_back(r);
    end
  endtask

  basis_res_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      dim_reg <= DIM_LINE;
      pending_res.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) dim_reg <= cfg_wdata;
      if (pt_mon.valid && pt_mon.ready)
        predict_point(pt_mon.coord_x, pt_mon.coord_y, pt_mon.coord_z);
      if (res_mon.valid && res_mon.ready) begin
        got.dof = res_mon.dof_index;
        got.term = {res_mon.hess_yz, res_mon.hess_xz, res_mon.hess_xy, res_mon.hess_zz,
                    res_mon.hess_yy, res_mon.hess_xx, res_mon.grad_z, res_mon.grad_y,
                    res_mon.grad_x, res_mon.basis_value};
        got.last = res_mon.last_dof;
        if (pending_res.size() == 0) begin
          $display("%0t unexpected result dof %0d", $time, got.dof);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_res.pop_front();
          if (got !== want) begin
            $display("%0t mismatch exp dof %0d last %0b terms %p", $time, want.dof,
                     want.last, want.term);
            $display("%0t          act dof %0d last %0b terms %p", $time, got.dof,
                     got.last, got.term);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = pending_res.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: stimulus, configuration phases and verdict for the hermite basis core
module tb_top;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_wdata = '0;
  int fail_count, pending_count;
  int hold_cycles = 0;
  bit drain_stall = 0;

  chb_in_if pt_ch();
  chb_out_if res_ch();

  always #1 clk = ~clk;

  cubic_hermite_tensor_basis_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pt_in(pt_ch.sink), .res_out(res_ch.source)
  );

  chb_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pt_mon(pt_ch), .res_mon(res_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    pt_ch.valid = 0;
    pt_ch.coord_x = '0;
    pt_ch.coord_y = '0;
    pt_ch.coord_z = '0;
    res_ch.ready = 0;
  end

  // receiver: random gaps per result, plus an occasional long hold-off
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res_ch.ready <= 0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = drain_stall ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        res_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // random coordinate, mostly in range, sometimes at or beyond the edges
  function automatic logic signed [17:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 18'sh10000;
      1: return -18'sh10000;
      2: return 18'(32'($urandom()));
      3: return 18'($urandom_range(0, 8) - 4);
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // valid stays up after a transfer so back-to-back points need no second drive
  task automatic send_point(logic signed [17:0] cx, logic signed [17:0] cy,
                            logic signed [17:0] cz, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pt_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    pt_ch.valid <= 1;
    pt_ch.coord_x <= cx;
    pt_ch.coord_y <= cy;
    pt_ch.coord_z <= cz;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid, wait for all expected results, then let the pipeline settle
  task automatic wait_idle();
    pt_ch.valid <= 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_dim(logic [1:0] d);
    wait_idle();
    cfg_we <= 1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [1:0] dims[8];
    dims = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, exact zero and out-of-range points, reset dimension first
    send_point(18'sh10000, -18'sh10000, 18'sd0, 0);
    send_point(-18'sh10000, 18'sh10000, 18'sh10000, 0);
    foreach (dims[i]) begin
      if (i < 4) begin
        set_dim(dims[i]);
        send_point(18'sd0, 18'sd0, 18'sd0, 0);
        send_point(18'sh10000, 18'sh10000, -18'sh10000, 0);
        send_point(18'sh1ffff, -18'sh20000, 18'sh1ffff, 0);
        send_point(-18'sh20000, 18'sh1ffff, -18'sh20000, 0);
        send_point(18'sd1, -18'sd1, 18'sd32768, 0);
      end
    end
    // random phases over all settings
    foreach (dims[i]) begin
      set_dim(dims[i]);
      for (int n = 0; n < 50; n++) begin
        if (n == 10 && (i == 1 || i == 4)) begin
          hold_cycles = 400;
          for (int b = 0; b < 4; b++) send_point(pick_coord(), pick_coord(), pick_coord(), 1);
        end
        if (n == 30) wait_idle();
        send_point(pick_coord(), pick_coord(), pick_coord(), 0);
      end
    end
    drain_stall = 1;
    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
